FILE: rtl/scfl_pkg.sv
package scfl_pkg;

  // Ring geometry.
  localparam int RECORDS  = 32;
  localparam int MAX_OUT  = 32;
  localparam int IDX_W    = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CNT_W    = $clog2(RECORDS + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int EMIT_MAX = (RECORDS < MAX_OUT) ? RECORDS : MAX_OUT;

  // Sequence coding: values count modulo 255 and the top code marks an empty slot.
  localparam logic [7:0] SEQ_EMPTY = 8'hFF;
  localparam logic [7:0] SEQ_LAST  = 8'd254;

  // Request codes.
  localparam logic [2:0] REQ_SUBMIT  = 3'd0;
  localparam logic [2:0] REQ_DUMP    = 3'd1;
  localparam logic [2:0] REQ_ERASE   = 3'd2;
  localparam logic [2:0] REQ_RESTORE = 3'd3;
  localparam logic [2:0] REQ_RECOVER = 3'd4;

  // Result kinds.
  localparam logic [1:0] RESP_ACK   = 2'd0;
  localparam logic [1:0] RESP_REC   = 2'd1;
  localparam logic [1:0] RESP_BLANK = 2'd2;

  // One stored fault record.
  typedef struct packed {
    logic [7:0]  seq;
    logic [31:0] ts;
    logic [7:0]  kind;
    logic [63:0] plo;
    logic [15:0] phi;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Contents of a slot that was never written since reset.
  localparam rec_t REC_RESET = '{seq: SEQ_EMPTY, ts: '0, kind: '0, plo: '0, phi: '0};

  function automatic logic [7:0] seq_next(input logic [7:0] s);
    seq_next = (s == SEQ_LAST) ? 8'd0 : s + 8'd1;
  endfunction

  function automatic logic [7:0] seq_prev(input logic [7:0] s);
    seq_prev = (s == 8'd0) ? SEQ_LAST : s - 8'd1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == IDX_W'(RECORDS - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    idx_dec = (i == '0) ? IDX_W'(RECORDS - 1) : i - IDX_W'(1);
  endfunction

endpackage

FILE: rtl/scfl_ram.sv
module scfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/sequenced_circular_fault_log_top.sv
// Circular fault log with sequence-number recovery.
//
// A request beat is taken on a rising edge with start_i high and busy_o low.
// Results leave as single-cycle beats marked by resp_valid_o; last_o flags
// the final beat of a request. The receiver cannot hold results off.
//
// Submit, erase, restore and unused codes give one registered acknowledgement
// beat after acceptance and leave busy_o low, so the next request may follow
// at once. A dump that finds the log blank answers with one blank beat after
// reading slot 0. Otherwise a dump walks back from the head over the
// consecutive run (at most RECORDS slots), then emits the newest records of
// it (at most 32), one beat per cycle; a run that spans the whole ring ends
// the walk without reading a slot past it. Recover scans at most every slot
// plus the first one again. The walk, emit and scans are paced by the single
// read port of the record RAM, which yields one slot per cycle.
//
// After reset the head and the next sequence are zero and every slot reads as
// empty through per-slot flags, so no clearing pass is needed. Erase works the
// same way and leaves busy_o low.
module sequenced_circular_fault_log_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  slot_index_i,
  input  logic [7:0]  raw_sequence_i,
  input  logic [31:0] timestamp_i,
  input  logic [7:0]  fault_type_i,
  input  logic [63:0] payload_low_i,
  input  logic [15:0] payload_high_i,
  output logic        resp_valid_o,
  output logic [1:0]  resp_kind_o,
  output logic [7:0]  out_sequence_o,
  output logic [4:0]  out_slot_o,
  output logic [31:0] out_timestamp_o,
  output logic [7:0]  out_fault_type_o,
  output logic [63:0] out_payload_low_o,
  output logic [15:0] out_payload_high_o,
  output logic        last_o,
  output logic        corrupt_o
);

  localparam int IDX_W = scfl_pkg::IDX_W;
  localparam int CNT_W = scfl_pkg::CNT_W;
  localparam int SUM_W = scfl_pkg::SUM_W;
  localparam int NREC  = scfl_pkg::RECORDS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLANK,
    ST_WALK,
    ST_EMIT,
    ST_RECOVER
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0] head_q, head_d;
  logic [7:0]       nseq_q, nseq_d;
  logic [NREC-1:0]  written_q, written_d;
  logic [NREC-1:0]  erased_q, erased_d;
  logic             rd_written_q, rd_erased_q;

  // Walk, emit and scan bookkeeping.
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       prev_q, prev_d;

  // Output register.
  logic        rv_q, rv_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  oseq_q, oseq_d;
  logic [4:0]  oslot_q, oslot_d;
  scfl_pkg::rec_t orec_q, orec_d;
  logic        last_q, last_d;
  logic        corrupt_q, corrupt_d;

  // RAM ports.
  logic             we;
  logic [IDX_W-1:0] waddr;
  scfl_pkg::rec_t   wdata;
  logic [IDX_W-1:0] raddr;
  logic [scfl_pkg::REC_W-1:0] ram_rdata;
  scfl_pkg::rec_t   rd_rec;

  // Temporaries for the end of a walk.
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] emit_n;
  logic [CNT_W-1:0] head_w;
  logic [IDX_W-1:0] start_pos;
  logic             walk_take;
  logic             walk_done;

  scfl_ram #(
    .WIDTH(scfl_pkg::REC_W),
    .DEPTH(NREC)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // A slot not written since reset or erase reads as its cleared value.
  always_comb begin
    if (rd_written_q) begin
      rd_rec = scfl_pkg::rec_t'(ram_rdata);
    end else if (rd_erased_q) begin
      rd_rec = '1;
    end else begin
      rd_rec = scfl_pkg::REC_RESET;
    end
  end

  // Request sequencer: next state, RAM accesses and the next result beat.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    nseq_d    = nseq_q;
    written_d = written_q;
    erased_d  = erased_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    prev_d    = prev_q;

    rv_d      = 1'b0;
    kind_d    = kind_q;
    oseq_d    = oseq_q;
    oslot_d   = oslot_q;
    orec_d    = orec_q;
    last_d    = last_q;
    corrupt_d = corrupt_q;

    we    = 1'b0;
    waddr = head_q;
    wdata = '0;
    raddr = '0;

    run_len   = cnt_q;
    emit_n    = cnt_q;
    head_w    = CNT_W'(head_q);
    start_pos = '0;
    walk_take = 1'b0;
    walk_done = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          // Default acknowledgement; the cases below refine it.
          rv_d      = 1'b1;
          kind_d    = scfl_pkg::RESP_ACK;
          oseq_d    = 8'd0;
          oslot_d   = 5'(head_q);
          orec_d    = '0;
          last_d    = 1'b1;
          corrupt_d = 1'b0;
          unique case (req_type_i)
            scfl_pkg::REQ_SUBMIT: begin
              we                = 1'b1;
              waddr             = head_q;
              wdata.seq         = nseq_q;
              wdata.ts          = timestamp_i;
              wdata.kind        = fault_type_i;
              wdata.plo         = payload_low_i;
              wdata.phi         = payload_high_i;
              written_d[head_q] = 1'b1;
              head_d            = scfl_pkg::idx_inc(head_q);
              nseq_d            = scfl_pkg::seq_next(nseq_q);
              oseq_d            = nseq_q;
              oslot_d           = 5'(scfl_pkg::idx_inc(head_q));
            end
            scfl_pkg::REQ_DUMP: begin
              // Read slot 0 first for the blank-log check.
              rv_d    = 1'b0;
              raddr   = '0;
              state_d = ST_BLANK;
            end
            scfl_pkg::REQ_ERASE: begin
              written_d = '0;
              erased_d  = '1;
              head_d    = '0;
              nseq_d    = 8'd0;
              oslot_d   = 5'd0;
            end
            scfl_pkg::REQ_RESTORE: begin
              if (int'(slot_index_i) < NREC) begin
                we                = 1'b1;
                waddr             = IDX_W'(slot_index_i);
                wdata.seq         = raw_sequence_i;
                wdata.ts          = timestamp_i;
                wdata.kind        = fault_type_i;
                wdata.plo         = payload_low_i;
                wdata.phi         = payload_high_i;
                written_d[IDX_W'(slot_index_i)] = 1'b1;
              end
            end
            scfl_pkg::REQ_RECOVER: begin
              rv_d    = 1'b0;
              raddr   = '0;
              cnt_d   = '0;
              state_d = ST_RECOVER;
            end
            default: begin
              // Unused codes only acknowledge.
            end
          endcase
        end
      end

      ST_BLANK: begin
        if (head_q == '0 && rd_rec.seq == scfl_pkg::SEQ_EMPTY) begin
          rv_d      = 1'b1;
          kind_d    = scfl_pkg::RESP_BLANK;
          oseq_d    = 8'd0;
          oslot_d   = 5'(head_q);
          orec_d    = '0;
          last_d    = 1'b1;
          corrupt_d = 1'b0;
          state_d   = ST_IDLE;
        end else begin
          // The slot before the head is always taken.
          pos_d   = scfl_pkg::idx_dec(head_q);
          raddr   = scfl_pkg::idx_dec(head_q);
          cnt_d   = '0;
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        // Data for pos_q arrives now; extend the run while sequences chain.
        walk_take = (cnt_q == '0) ||
                    (rd_rec.seq != scfl_pkg::SEQ_EMPTY &&
                     rd_rec.seq == scfl_pkg::seq_prev(prev_q));
        if (walk_take) begin
          run_len   = cnt_q + CNT_W'(1);
          walk_done = (run_len == CNT_W'(NREC));
        end else begin
          run_len   = cnt_q;
          walk_done = 1'b1;
        end
        if (walk_done) begin
          // Emit the newest records of the run, oldest first.
          emit_n = (int'(run_len) > scfl_pkg::EMIT_MAX) ?
                   CNT_W'(scfl_pkg::EMIT_MAX) : run_len;
          if (head_w >= emit_n) begin
            start_pos = IDX_W'(head_w - emit_n);
          end else begin
            start_pos = IDX_W'(SUM_W'(head_w) + SUM_W'(NREC) - SUM_W'(emit_n));
          end
          raddr   = start_pos;
          pos_d   = start_pos;
          cnt_d   = emit_n;
          state_d = ST_EMIT;
        end else begin
          prev_d = rd_rec.seq;
          cnt_d  = run_len;
          pos_d  = scfl_pkg::idx_dec(pos_q);
          raddr  = scfl_pkg::idx_dec(pos_q);
        end
      end

      ST_EMIT: begin
        rv_d      = 1'b1;
        kind_d    = scfl_pkg::RESP_REC;
        oseq_d    = rd_rec.seq;
        oslot_d   = 5'(pos_q);
        orec_d    = rd_rec;
        last_d    = (cnt_q == CNT_W'(1));
        corrupt_d = 1'b0;
        cnt_d     = cnt_q - CNT_W'(1);
        pos_d     = scfl_pkg::idx_inc(pos_q);
        raddr     = scfl_pkg::idx_inc(pos_q);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_RECOVER: begin
        // cnt_q is the slot whose data arrives now; the last step rereads slot 0.
        rv_d      = 1'b1;
        kind_d    = scfl_pkg::RESP_ACK;
        oseq_d    = 8'd0;
        orec_d    = '0;
        last_d    = 1'b1;
        corrupt_d = 1'b0;
        state_d   = ST_IDLE;
        if (cnt_q != '0 && rd_rec.seq != scfl_pkg::seq_next(prev_q)) begin
          // The chain breaks between the previous slot and this one.
          head_d  = (cnt_q == CNT_W'(NREC)) ? '0 : IDX_W'(cnt_q);
          nseq_d  = scfl_pkg::seq_next(prev_q);
          oslot_d = (cnt_q == CNT_W'(NREC)) ? 5'd0 : 5'(cnt_q);
        end else if (cnt_q == CNT_W'(NREC)) begin
          // Every slot chains into the next: no head can be found.
          head_d    = '0;
          nseq_d    = 8'd0;
          oslot_d   = 5'd0;
          corrupt_d = 1'b1;
        end else if (rd_rec.seq == scfl_pkg::SEQ_EMPTY) begin
          head_d  = IDX_W'(cnt_q);
          nseq_d  = 8'd0;
          oslot_d = 5'(cnt_q);
        end else begin
          rv_d    = 1'b0;
          state_d = ST_RECOVER;
          prev_d  = rd_rec.seq;
          cnt_d   = cnt_q + CNT_W'(1);
          raddr   = (cnt_q == CNT_W'(NREC - 1)) ? '0 : IDX_W'(cnt_q + CNT_W'(1));
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, log pointers, slot flags and the result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      nseq_q       <= 8'd0;
      written_q    <= '0;
      erased_q     <= '0;
      rd_written_q <= 1'b0;
      rd_erased_q  <= 1'b0;
      pos_q        <= '0;
      cnt_q        <= '0;
      prev_q       <= 8'd0;
      rv_q         <= 1'b0;
      kind_q       <= scfl_pkg::RESP_ACK;
      oseq_q       <= 8'd0;
      oslot_q      <= 5'd0;
      orec_q       <= '0;
      last_q       <= 1'b0;
      corrupt_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      nseq_q       <= nseq_d;
      written_q    <= written_d;
      erased_q     <= erased_d;
      rd_written_q <= written_q[raddr];
      rd_erased_q  <= erased_q[raddr];
      pos_q        <= pos_d;
      cnt_q        <= cnt_d;
      prev_q       <= prev_d;
      rv_q         <= rv_d;
      kind_q       <= kind_d;
      oseq_q       <= oseq_d;
      oslot_q      <= oslot_d;
      orec_q       <= orec_d;
      last_q       <= last_d;
      corrupt_q    <= corrupt_d;
    end
  end

  assign busy_o             = (state_q != ST_IDLE);
  assign resp_valid_o       = rv_q;
  assign resp_kind_o        = kind_q;
  assign out_sequence_o     = oseq_q;
  assign out_slot_o         = oslot_q;
  assign out_timestamp_o    = orec_q.ts;
  assign out_fault_type_o   = orec_q.kind;
  assign out_payload_low_o  = orec_q.plo;
  assign out_payload_high_o = orec_q.phi;
  assign last_o             = last_q;
  assign corrupt_o          = corrupt_q;

endmodule

FILE: rtl/scfl_checker.sv
module scfl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [2:0]  req_type_i,
  input logic [4:0]  slot_index_i,
  input logic [7:0]  raw_sequence_i,
  input logic [31:0] timestamp_i,
  input logic [7:0]  fault_type_i,
  input logic [63:0] payload_low_i,
  input logic [15:0] payload_high_i,
  input logic        resp_valid_o,
  input logic [1:0]  resp_kind_o,
  input logic [7:0]  out_sequence_o,
  input logic [4:0]  out_slot_o,
  input logic [31:0] out_timestamp_o,
  input logic [7:0]  out_fault_type_o,
  input logic [63:0] out_payload_low_o,
  input logic [15:0] out_payload_high_o,
  input logic        last_o,
  input logic        corrupt_o
);

  // An accepted request either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || resp_valid_o)
    else $error("accepted request neither answered nor started");

  // A beat that is not the last one leaves the block busy for the rest.
  a_more_beats_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && !last_o |-> busy_o)
    else $error("non-final beat while the block is idle");

  // Finishing a long request always coincides with its final beat.
  a_finish_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> resp_valid_o && last_o)
    else $error("request finished without a final beat");

  // A blank-log answer is a single beat.
  a_blank_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && resp_kind_o == scfl_pkg::RESP_BLANK |-> last_o)
    else $error("blank-log answer is not final");

  // Corruption is reported only on a final acknowledgement.
  a_corrupt_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && corrupt_o |->
      resp_kind_o == scfl_pkg::RESP_ACK && last_o && out_slot_o == 5'd0)
    else $error("corrupt flag on an unexpected beat");

endmodule

bind sequenced_circular_fault_log_top scfl_checker u_scfl_checker (.*);
